### rtl/tcpcsm_pkg.sv
package tcpcsm_pkg;

  typedef enum logic [3:0] {
    ST_CLOSED      = 4'd0,
    ST_LISTEN      = 4'd1,
    ST_SYN_SENT    = 4'd2,
    ST_SYN_RCVD    = 4'd3,
    ST_ESTABLISHED = 4'd4,
    ST_FIN_WAIT_1  = 4'd5,
    ST_FIN_WAIT_2  = 4'd6,
    ST_CLOSING     = 4'd7,
    ST_TIME_WAIT   = 4'd8,
    ST_CLOSE_WAIT  = 4'd9,
    ST_LAST_ACK    = 4'd10
  } tcp_state_t;

  typedef enum logic [2:0] {
    MODE_SEGMENT = 3'd0,
    MODE_CONNECT = 3'd1,
    MODE_CLOSE   = 3'd2,
    MODE_SEND    = 3'd3,
    MODE_LISTEN  = 3'd4
  } mode_t;

  localparam logic [7:0] FLAG_FIN = 8'h01;
  localparam logic [7:0] FLAG_SYN = 8'h02;
  localparam logic [7:0] FLAG_RST = 8'h04;
  localparam logic [7:0] FLAG_PSH = 8'h08;
  localparam logic [7:0] FLAG_ACK = 8'h10;

  localparam logic [15:0] RX_WINDOW_RESET = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic [7:0]  seg_flags;
    logic [15:0] data_bytes;
    logic [31:0] peer_addr;
    logic [15:0] peer_port;
    logic [31:0] initial_seq;
  } item_t;

  typedef struct packed {
    logic        is_segment;
    logic [31:0] out_seq;
    logic [31:0] out_ack;
    logic [7:0]  out_flags;
    logic [15:0] out_window;
    logic [15:0] payload_len;
    logic [31:0] dest_addr;
    logic [15:0] dest_port;
    tcp_state_t  conn_state;
    logic        notify_app;
    logic        last;
  } result_t;

endpackage

### rtl/tcpcsm_in_reg.sv
module tcpcsm_in_reg import tcpcsm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t in_item,
  input  logic  take,
  output logic  q_valid,
  output item_t q_item
);

  logic accept;

  // register frees up in the same cycle its request is taken
  assign in_stall = q_valid && !take;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (accept) begin
      q_valid <= 1'b1;
    end else if (take) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_item <= in_item;
    end
  end

endmodule

### rtl/tcpcsm_engine.sv
module tcpcsm_engine import tcpcsm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  item_t       item,
  input  logic        fire,
  output logic [1:0]  res_cnt,
  output result_t     res0,
  output result_t     res1
);

  typedef struct packed {
    logic        seg;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [7:0]  flags;
    logic [15:0] win;
    logic [15:0] plen;
  } hdr_t;

  tcp_state_t  st, state_next;
  logic [31:0] sn, sn_next;
  logic [31:0] rn, rn_next;
  logic [31:0] una, una_next;
  logic [31:0] raddr, raddr_next;
  logic [15:0] rport, rport_next;
  logic [15:0] win;

  logic        f_fin, f_syn, f_rst, f_ack;
  logic        ack_ok, len_nz, seq_ok, fin_taken, est_go;
  logic [31:0] len32, seq_p1, rn_len, rn_a, rn_b;
  hdr_t        h0, h1;
  logic [1:0]  nseg;
  logic        wake;

  function automatic hdr_t mk_hdr(logic [31:0] s, logic [31:0] a, logic [7:0] f,
                                  logic [15:0] w, logic [15:0] p);
    hdr_t h;
    h.seg   = 1'b1;
    h.seq   = s;
    h.ack   = a;
    h.flags = f;
    h.win   = w;
    h.plen  = p;
    return h;
  endfunction

  assign f_fin  = |(item.seg_flags & FLAG_FIN);
  assign f_syn  = |(item.seg_flags & FLAG_SYN);
  assign f_rst  = |(item.seg_flags & FLAG_RST);
  assign f_ack  = |(item.seg_flags & FLAG_ACK);
  assign ack_ok = f_ack && (item.ack_num == sn);
  assign len_nz = item.data_bytes != 16'd0;
  assign seq_ok = item.seq_num == rn;
  assign len32  = {16'd0, item.data_bytes};
  assign seq_p1 = item.seq_num + 32'd1;
  assign rn_len = rn + len32;

  // fin wait states: fin moves rcv_nxt to seq+1, payload is then added unchecked
  always_comb begin
    fin_taken = 1'b0;
    if (st == ST_FIN_WAIT_1) begin
      fin_taken = f_ack ? (ack_ok && f_fin) : f_fin;
    end else if (st == ST_FIN_WAIT_2) begin
      fin_taken = f_fin;
    end
  end
  assign rn_a = fin_taken ? seq_p1 : rn;
  assign rn_b = rn_a + len32;

  assign est_go = (st == ST_ESTABLISHED) || ((st == ST_SYN_RCVD) && ack_ok && len_nz);

  // next connection state
  always_comb begin
    state_next = st;
    unique case (item.mode)
      MODE_SEGMENT: begin
        if (f_rst) begin
          state_next = ST_CLOSED;
        end else begin
          unique case (st)
            ST_LISTEN: begin
              if (f_syn) state_next = ST_SYN_RCVD;
            end
            ST_SYN_SENT: begin
              if (f_syn && f_ack) begin
                if (item.ack_num == sn) state_next = ST_ESTABLISHED;
              end else if (f_syn) begin
                state_next = ST_SYN_RCVD;
              end
            end
            ST_SYN_RCVD: begin
              if (ack_ok) begin
                if (len_nz && seq_ok && f_fin) state_next = ST_CLOSE_WAIT;
                else                           state_next = ST_ESTABLISHED;
              end
            end
            ST_ESTABLISHED: begin
              if (f_fin && (!len_nz || seq_ok)) state_next = ST_CLOSE_WAIT;
            end
            ST_FIN_WAIT_1: begin
              if (f_ack) begin
                if (ack_ok) state_next = f_fin ? ST_TIME_WAIT : ST_FIN_WAIT_2;
              end else if (f_fin) begin
                state_next = ST_CLOSING;
              end
            end
            ST_FIN_WAIT_2: begin
              if (f_fin) state_next = ST_TIME_WAIT;
            end
            ST_CLOSING: begin
              if (ack_ok) state_next = ST_TIME_WAIT;
            end
            ST_LAST_ACK: begin
              if (ack_ok) state_next = ST_CLOSED;
            end
            default: ;
          endcase
        end
      end
      MODE_CONNECT: state_next = ST_SYN_SENT;
      MODE_CLOSE: begin
        unique case (st)
          ST_CLOSED, ST_LISTEN, ST_SYN_SENT: state_next = ST_CLOSED;
          ST_SYN_RCVD, ST_ESTABLISHED:       state_next = ST_FIN_WAIT_1;
          ST_CLOSE_WAIT:                     state_next = ST_LAST_ACK;
          default: ;
        endcase
      end
      MODE_LISTEN: state_next = ST_LISTEN;
      default: ;
    endcase
  end

  // sequence numbers, peer and emitted headers
  always_comb begin
    sn_next    = sn;
    rn_next    = rn;
    una_next   = una;
    raddr_next = raddr;
    rport_next = rport;
    h0         = '0;
    h1         = '0;
    nseg       = 2'd0;
    wake       = 1'b0;
    unique case (item.mode)
      MODE_SEGMENT: begin
        if (f_rst) begin
          wake = 1'b1;
        end else begin
          unique case (st)
            ST_CLOSED: begin
              // reset reply, window zero
              nseg = 2'd1;
              if (f_ack) begin
                h0 = mk_hdr(item.ack_num, 32'd0, FLAG_RST, 16'd0, 16'd0);
              end else begin
                h0 = mk_hdr(32'd0, item.seq_num + len32 + {31'd0, f_syn},
                            FLAG_RST | FLAG_ACK, 16'd0, 16'd0);
              end
            end
            ST_LISTEN: begin
              if (f_syn) begin
                rn_next    = seq_p1;
                sn_next    = item.initial_seq + 32'd1;
                raddr_next = item.peer_addr;
                rport_next = item.peer_port;
                h0         = mk_hdr(item.initial_seq, seq_p1, FLAG_SYN | FLAG_ACK, win, 16'd0);
                nseg       = 2'd1;
              end
            end
            ST_SYN_SENT: begin
              if (f_syn && f_ack) begin
                if (item.ack_num == sn) begin
                  una_next = item.ack_num;
                  rn_next  = seq_p1;
                  h0       = mk_hdr(item.ack_num, seq_p1, FLAG_ACK, win, 16'd0);
                  nseg     = 2'd1;
                  wake     = 1'b1;
                end
              end else if (f_syn) begin
                // simultaneous open: syn already took one number
                rn_next = seq_p1;
                h0      = mk_hdr(sn - 32'd1, seq_p1, FLAG_SYN | FLAG_ACK, win, 16'd0);
                nseg    = 2'd1;
              end
            end
            ST_SYN_RCVD, ST_ESTABLISHED: begin
              if ((st == ST_SYN_RCVD) && ack_ok) begin
                una_next = item.ack_num;
                wake     = 1'b1;
              end
              if (est_go) begin
                if (len_nz) begin
                  if (!seq_ok) begin
                    h0   = mk_hdr(sn, rn, FLAG_ACK, win, 16'd0);
                    nseg = 2'd1;
                  end else begin
                    wake = 1'b1;
                    h0   = mk_hdr(sn, rn_len, FLAG_ACK, win, 16'd0);
                    if (f_fin) begin
                      rn_next = rn_len + 32'd1;
                      h1      = mk_hdr(sn, rn_len + 32'd1, FLAG_ACK, win, 16'd0);
                      nseg    = 2'd2;
                    end else begin
                      rn_next = rn_len;
                      nseg    = 2'd1;
                    end
                  end
                end else if (f_fin) begin
                  rn_next = rn + 32'd1;
                  h0      = mk_hdr(sn, rn + 32'd1, FLAG_ACK, win, 16'd0);
                  nseg    = 2'd1;
                  wake    = 1'b1;
                end
              end
            end
            ST_FIN_WAIT_1, ST_FIN_WAIT_2: begin
              if ((st == ST_FIN_WAIT_1) && ack_ok) una_next = item.ack_num;
              rn_next = len_nz ? rn_b : rn_a;
              wake    = len_nz;
              nseg    = {1'b0, fin_taken} + {1'b0, len_nz};
              h0      = fin_taken ? mk_hdr(sn, rn_a, FLAG_ACK, win, 16'd0)
                                  : mk_hdr(sn, rn_b, FLAG_ACK, win, 16'd0);
              h1      = mk_hdr(sn, rn_b, FLAG_ACK, win, 16'd0);
            end
            ST_CLOSING: begin
              if (ack_ok) una_next = item.ack_num;
            end
            ST_TIME_WAIT: begin
              if (f_fin) begin
                h0   = mk_hdr(sn, rn, FLAG_ACK, win, 16'd0);
                nseg = 2'd1;
              end
            end
            ST_LAST_ACK: begin
              if (ack_ok) begin
                una_next = item.ack_num;
                wake     = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      MODE_CONNECT: begin
        raddr_next = item.peer_addr;
        rport_next = item.peer_port;
        sn_next    = item.initial_seq + 32'd1;
        h0         = mk_hdr(item.initial_seq, 32'd0, FLAG_SYN, win, 16'd0);
        nseg       = 2'd1;
      end
      MODE_CLOSE: begin
        if (st == ST_SYN_RCVD || st == ST_ESTABLISHED || st == ST_CLOSE_WAIT) begin
          h0      = mk_hdr(sn, rn, FLAG_FIN | FLAG_ACK, win, 16'd0);
          nseg    = 2'd1;
          sn_next = sn + 32'd1;
        end
      end
      MODE_SEND: begin
        h0      = mk_hdr(sn, rn, FLAG_PSH | FLAG_ACK, win, item.data_bytes);
        nseg    = 2'd1;
        sn_next = sn + len32;
      end
      default: ;
    endcase
  end

  // build the results; a lone wake-up becomes one result without a segment
  always_comb begin
    res_cnt = (wake && nseg == 2'd0) ? 2'd1 : nseg;

    res0.is_segment  = h0.seg;
    res0.out_seq     = h0.seq;
    res0.out_ack     = h0.ack;
    res0.out_flags   = h0.flags;
    res0.out_window  = h0.win;
    res0.payload_len = h0.plen;
    res0.dest_addr   = raddr_next;
    res0.dest_port   = rport_next;
    res0.conn_state  = state_next;
    res0.last        = res_cnt == 2'd1;
    res0.notify_app  = wake && (res_cnt == 2'd1);

    res1.is_segment  = h1.seg;
    res1.out_seq     = h1.seq;
    res1.out_ack     = h1.ack;
    res1.out_flags   = h1.flags;
    res1.out_window  = h1.win;
    res1.payload_len = h1.plen;
    res1.dest_addr   = raddr_next;
    res1.dest_port   = rport_next;
    res1.conn_state  = state_next;
    res1.last        = 1'b1;
    res1.notify_app  = wake;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= ST_CLOSED;
      sn    <= '0;
      rn    <= '0;
      una   <= '0;
      raddr <= '0;
      rport <= '0;
    end else if (fire) begin
      st    <= state_next;
      sn    <= sn_next;
      rn    <= rn_next;
      una   <= una_next;
      raddr <= raddr_next;
      rport <= rport_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= RX_WINDOW_RESET;
    end else if (cfg_wr_en) begin
      win <= cfg_wr_data;
    end
  end

endmodule

### rtl/tcpcsm_out_queue.sv
module tcpcsm_out_queue import tcpcsm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_cnt,
  input  result_t    res0,
  input  result_t    res1,
  output logic [1:0] free,
  output logic       out_valid,
  input  logic       out_stall,
  output result_t    head
);

  result_t    slot0, slot1, slot0_next, slot1_next;
  logic [1:0] cnt, cnt_next, base;
  logic       pop;

  assign out_valid = cnt != 2'd0;
  assign head      = slot0;
  assign pop       = out_valid && !out_stall;
  assign free      = 2'd2 - cnt + {1'b0, pop};
  assign base      = cnt - {1'b0, pop};
  assign cnt_next  = base + push_cnt;

  // head always sits in slot0, entries shift down on a pop
  always_comb begin
    slot0_next = pop ? slot1 : slot0;
    slot1_next = slot1;
    if (push_cnt != 2'd0) begin
      if (base == 2'd0) begin
        slot0_next = res0;
        slot1_next = res1;
      end else begin
        slot1_next = res0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    slot0 <= slot0_next;
    slot1 <= slot1_next;
  end

endmodule

### rtl/tcp_connection_state_machine.sv
// State machine of one TCP connection.
// Input channel (in_valid / in_stall) carries one event per request: an arriving
// segment header, or a connect, close, send-data or listen command. Output channel
// (out_valid / out_stall) returns zero to two results per request, in order; a
// result is a header to transmit or a bare application wake-up, and 'last' marks
// the final result of a request. cfg_wr_en / cfg_wr_data write the advertised
// receive window; write it only while no request is in flight.
// A request lands in the input register and is evaluated combinationally against
// the connection registers; its results are written into a two-entry result queue
// whose head drives the output. Results leave at one per cycle while out_stall is
// low, and a new request is accepted as soon as the pending one is evaluated.
// When the receiver stalls, the queue holds its results; once it has no room for
// the pending request, in_stall rises and holds the input register.
// Reset: state CLOSED, sequence numbers and peer cleared, window 65535, queue empty.
module tcp_connection_state_machine import tcpcsm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  mode,
  input  logic [31:0] seq_num,
  input  logic [31:0] ack_num,
  input  logic [7:0]  seg_flags,
  input  logic [15:0] data_bytes,
  input  logic [31:0] peer_addr,
  input  logic [15:0] peer_port_in,
  input  logic [31:0] initial_seq,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        is_segment,
  output logic [31:0] out_seq,
  output logic [31:0] out_ack,
  output logic [7:0]  out_flags,
  output logic [15:0] out_window,
  output logic [15:0] payload_len,
  output logic [31:0] dest_addr,
  output logic [15:0] dest_port,
  output logic [3:0]  conn_state,
  output logic        notify_app,
  output logic        last
);

  item_t      in_item, q_item;
  logic       q_valid, fire;
  logic [1:0] res_cnt, free, push_cnt;
  result_t    res0, res1, head;

  always_comb begin
    in_item.mode        = mode;
    in_item.seq_num     = seq_num;
    in_item.ack_num     = ack_num;
    in_item.seg_flags   = seg_flags;
    in_item.data_bytes  = data_bytes;
    in_item.peer_addr   = peer_addr;
    in_item.peer_port   = peer_port_in;
    in_item.initial_seq = initial_seq;
  end

  // evaluate only when the queue can hold every result of the request
  assign fire     = q_valid && (res_cnt <= free);
  assign push_cnt = fire ? res_cnt : 2'd0;

  tcpcsm_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .take     (fire),
    .q_valid  (q_valid),
    .q_item   (q_item)
  );

  tcpcsm_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item        (q_item),
    .fire        (fire),
    .res_cnt     (res_cnt),
    .res0        (res0),
    .res1        (res1)
  );

  tcpcsm_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push_cnt  (push_cnt),
    .res0      (res0),
    .res1      (res1),
    .free      (free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign is_segment  = head.is_segment;
  assign out_seq     = head.out_seq;
  assign out_ack     = head.out_ack;
  assign out_flags   = head.out_flags;
  assign out_window  = head.out_window;
  assign payload_len = head.payload_len;
  assign dest_addr   = head.dest_addr;
  assign dest_port   = head.dest_port;
  assign conn_state  = head.conn_state;
  assign notify_app  = head.notify_app;
  assign last        = head.last;

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import tcpcsm_pkg::*;

  localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [2:0] MODE_UNUSED_HI = 3'd7;
  localparam int SETTLE_CYCLES = 6;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 200;

  typedef struct {
    item_t   ev;
    bit      typed;
    result_t hdr;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  mode = '0;
  logic [31:0] seq_num = '0;
  logic [31:0] ack_num = '0;
  logic [7:0]  seg_flags = '0;
  logic [15:0] data_bytes = '0;
  logic [31:0] peer_addr = '0;
  logic [15:0] peer_port_in = '0;
  logic [31:0] initial_seq = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        is_segment;
  logic [31:0] out_seq;
  logic [31:0] out_ack;
  logic [7:0]  out_flags;
  logic [15:0] out_window;
  logic [15:0] payload_len;
  logic [31:0] dest_addr;
  logic [15:0] dest_port;
  logic [3:0]  conn_state;
  logic        notify_app;
  logic        last;

  tcp_connection_state_machine dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .seq_num(seq_num), .ack_num(ack_num), .seg_flags(seg_flags),
    .data_bytes(data_bytes), .peer_addr(peer_addr), .peer_port_in(peer_port_in),
    .initial_seq(initial_seq),
    .out_valid(out_valid), .out_stall(out_stall),
    .is_segment(is_segment), .out_seq(out_seq), .out_ack(out_ack),
    .out_flags(out_flags), .out_window(out_window), .payload_len(payload_len),
    .dest_addr(dest_addr), .dest_port(dest_port), .conn_state(conn_state),
    .notify_app(notify_app), .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // connection image kept by the testbench
  tcp_state_t  conn_st = ST_CLOSED;
  logic [31:0] snd_nxt = '0;
  logic [31:0] rcv_nxt = '0;
  logic [31:0] snd_una = '0;
  logic [31:0] peer_ip = '0;
  logic [15:0] peer_tcp_port = '0;
  logic [15:0] adv_win = RX_WINDOW_RESET;

  result_t hdr_out [2];
  int      hdr_n;
  bit      wake_app;

  result_t expected_hdrs [$];
  int      fail_count = 0;
  bit      tx_steady = 1'b0;
  bit      rx_steady = 1'b0;

  function automatic void emit_hdr(logic [31:0] s, logic [31:0] a, logic [7:0] f,
                                   logic [15:0] w, logic [15:0] l);
    if (hdr_n < 2) begin
      hdr_out[hdr_n] = '0;
      hdr_out[hdr_n].is_segment = 1'b1;
      hdr_out[hdr_n].out_seq = s;
      hdr_out[hdr_n].out_ack = a;
      hdr_out[hdr_n].out_flags = f;
      hdr_out[hdr_n].out_window = w;
      hdr_out[hdr_n].payload_len = l;
      hdr_n++;
    end
  endfunction

  function automatic void ack_now();
    emit_hdr(snd_nxt, rcv_nxt, FLAG_ACK, adv_win, '0);
  endfunction

  function automatic void take_data(logic [31:0] s, logic [15:0] len, logic [7:0] fl);
    if (len != 0) begin
      // out-of-sequence payload only gets a duplicate ack
      if (s != rcv_nxt) begin
        ack_now();
        return;
      end
      rcv_nxt += len;
      wake_app = 1'b1;
      ack_now();
    end
    if ((fl & FLAG_FIN) != 0) begin
      rcv_nxt += 1;
      conn_st = ST_CLOSE_WAIT;
      ack_now();
      wake_app = 1'b1;
    end
  endfunction

  // payload in the fin-wait states is taken without a sequence check
  function automatic void fin_wait_payload(logic [15:0] len);
    if (len != 0) begin
      rcv_nxt += len;
      wake_app = 1'b1;
      ack_now();
    end
  endfunction

  function automatic void on_segment(item_t it);
    logic [7:0]  fl;
    logic [31:0] rack;
    fl = it.seg_flags;
    if ((fl & FLAG_RST) != 0) begin
      conn_st = ST_CLOSED;
      wake_app = 1'b1;
      return;
    end
    case (conn_st)
      ST_CLOSED: begin
        if ((fl & FLAG_ACK) != 0) begin
          emit_hdr(it.ack_num, '0, FLAG_RST, '0, '0);
        end else begin
          rack = it.seq_num + 32'(it.data_bytes) + 32'((fl & FLAG_SYN) != 0);
          emit_hdr('0, rack, FLAG_RST | FLAG_ACK, '0, '0);
        end
      end
      ST_LISTEN: begin
        if ((fl & FLAG_SYN) != 0) begin
          conn_st = ST_SYN_RCVD;
          rcv_nxt = it.seq_num + 1;
          snd_nxt = it.initial_seq;
          peer_ip = it.peer_addr;
          peer_tcp_port = it.peer_port;
          emit_hdr(snd_nxt, rcv_nxt, FLAG_SYN | FLAG_ACK, adv_win, '0);
          snd_nxt += 1;
        end
      end
      ST_SYN_SENT: begin
        if ((fl & (FLAG_SYN | FLAG_ACK)) == (FLAG_SYN | FLAG_ACK)) begin
          if (it.ack_num == snd_nxt) begin
            conn_st = ST_ESTABLISHED;
            snd_una = it.ack_num;
            rcv_nxt = it.seq_num + 1;
            emit_hdr(snd_una, rcv_nxt, FLAG_ACK, adv_win, '0);
            wake_app = 1'b1;
          end
        end else if ((fl & FLAG_SYN) != 0) begin
          // simultaneous open: our syn already took one number
          conn_st = ST_SYN_RCVD;
          rcv_nxt = it.seq_num + 1;
          emit_hdr(snd_nxt - 1, rcv_nxt, FLAG_SYN | FLAG_ACK, adv_win, '0);
        end
      end
      ST_SYN_RCVD: begin
        if ((fl & FLAG_ACK) != 0 && it.ack_num == snd_nxt) begin
          conn_st = ST_ESTABLISHED;
          snd_una = it.ack_num;
          wake_app = 1'b1;
          if (it.data_bytes != 0) take_data(it.seq_num, it.data_bytes, fl);
        end
      end
      ST_ESTABLISHED: take_data(it.seq_num, it.data_bytes, fl);
      ST_FIN_WAIT_1: begin
        if ((fl & FLAG_ACK) != 0) begin
          // a fin riding on a stale ack is dropped
          if (it.ack_num == snd_nxt) begin
            snd_una = it.ack_num;
            if ((fl & FLAG_FIN) != 0) begin
              rcv_nxt = it.seq_num + 1;
              conn_st = ST_TIME_WAIT;
              ack_now();
            end else begin
              conn_st = ST_FIN_WAIT_2;
            end
          end
        end else if ((fl & FLAG_FIN) != 0) begin
          rcv_nxt = it.seq_num + 1;
          conn_st = ST_CLOSING;
          ack_now();
        end
        fin_wait_payload(it.data_bytes);
      end
      ST_FIN_WAIT_2: begin
        if ((fl & FLAG_FIN) != 0) begin
          rcv_nxt = it.seq_num + 1;
          conn_st = ST_TIME_WAIT;
          ack_now();
        end
        fin_wait_payload(it.data_bytes);
      end
      ST_CLOSING: begin
        if ((fl & FLAG_ACK) != 0 && it.ack_num == snd_nxt) begin
          snd_una = it.ack_num;
          conn_st = ST_TIME_WAIT;
        end
      end
      ST_TIME_WAIT: begin
        if ((fl & FLAG_FIN) != 0) ack_now();
      end
      ST_LAST_ACK: begin
        if ((fl & FLAG_ACK) != 0 && it.ack_num == snd_nxt) begin
          snd_una = it.ack_num;
          conn_st = ST_CLOSED;
          wake_app = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void on_close();
    case (conn_st)
      ST_CLOSED, ST_LISTEN, ST_SYN_SENT: conn_st = ST_CLOSED;
      ST_SYN_RCVD, ST_ESTABLISHED, ST_CLOSE_WAIT: begin
        emit_hdr(snd_nxt, rcv_nxt, FLAG_FIN | FLAG_ACK, adv_win, '0);
        snd_nxt += 1;
        conn_st = (conn_st == ST_CLOSE_WAIT) ? ST_LAST_ACK : ST_FIN_WAIT_1;
      end
      default: ;
    endcase
  endfunction

  // advances the connection image by one request and fills hdr_out
  function automatic void model_event(item_t it);
    hdr_n = 0;
    wake_app = 1'b0;
    case (it.mode)
      MODE_SEGMENT: on_segment(it);
      MODE_CONNECT: begin
        peer_ip = it.peer_addr;
        peer_tcp_port = it.peer_port;
        snd_nxt = it.initial_seq;
        conn_st = ST_SYN_SENT;
        emit_hdr(snd_nxt, '0, FLAG_SYN, adv_win, '0);
        snd_nxt += 1;
      end
      MODE_CLOSE: on_close();
      MODE_SEND: begin
        emit_hdr(snd_nxt, rcv_nxt, FLAG_PSH | FLAG_ACK, adv_win, it.data_bytes);
        snd_nxt += it.data_bytes;
      end
      MODE_LISTEN: conn_st = ST_LISTEN;
      default: ;
    endcase
    if (wake_app && hdr_n == 0) begin
      hdr_out[0] = '0;
      hdr_n = 1;
    end
    for (int k = 0; k < hdr_n; k++) begin
      hdr_out[k].dest_addr = peer_ip;
      hdr_out[k].dest_port = peer_tcp_port;
      hdr_out[k].conn_state = conn_st;
      hdr_out[k].notify_app = (k == hdr_n - 1) && wake_app;
      hdr_out[k].last = (k == hdr_n - 1);
    end
  endfunction

  function automatic item_t mk_event(logic [2:0] m, logic [31:0] s, logic [31:0] a,
                                     logic [7:0] f, logic [15:0] l, logic [31:0] pa,
                                     logic [15:0] pp, logic [31:0] isn);
    item_t it;
    it.mode = m;
    it.seq_num = s;
    it.ack_num = a;
    it.seg_flags = f;
    it.data_bytes = l;
    it.peer_addr = pa;
    it.peer_port = pp;
    it.initial_seq = isn;
    return it;
  endfunction

  // single result of a request while the peer is still unknown
  function automatic result_t mk_hdr(logic seg, logic [31:0] s, logic [31:0] a,
                                     logic [7:0] f, logic [15:0] w, logic [15:0] l,
                                     tcp_state_t st, logic wake);
    result_t r;
    r = '0;
    r.is_segment = seg;
    r.out_seq = s;
    r.out_ack = a;
    r.out_flags = f;
    r.out_window = w;
    r.payload_len = l;
    r.conn_state = st;
    r.notify_app = wake;
    r.last = 1'b1;
    return r;
  endfunction

  // mostly requests that fit the current state, some noise
  function automatic item_t draw_event();
    item_t      it;
    int         roll;
    logic [7:0] fl;
    it.mode = MODE_SEGMENT;
    it.seq_num = $urandom();
    it.ack_num = $urandom();
    it.seg_flags = 8'($urandom());
    it.data_bytes = 16'($urandom());
    it.peer_addr = $urandom();
    it.peer_port = 16'($urandom());
    it.initial_seq = $urandom();
    if ($urandom_range(0, 99) < 8) begin
      it.mode = 3'($urandom_range(0, 7));
      return it;
    end
    roll = $urandom_range(0, 99);
    if (conn_st == ST_CLOSED && roll < 50) it.mode = (roll < 30) ? MODE_CONNECT : MODE_LISTEN;
    else if (roll < 70) it.mode = MODE_SEGMENT;
    else if (roll < 82) it.mode = MODE_SEND;
    else if (roll < 92) it.mode = MODE_CLOSE;
    else if (roll < 96) it.mode = MODE_CONNECT;
    else it.mode = MODE_LISTEN;
    if ($urandom_range(0, 4) != 0) it.seq_num = rcv_nxt;
    if ($urandom_range(0, 4) != 0) it.ack_num = snd_nxt;
    if ($urandom_range(0, 19) != 0) begin
      it.data_bytes = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(1, 64));
    end
    case (conn_st)
      ST_LISTEN:      fl = FLAG_SYN;
      ST_SYN_SENT:    fl = ($urandom_range(0, 3) == 0) ? FLAG_SYN : (FLAG_SYN | FLAG_ACK);
      ST_SYN_RCVD:    fl = ($urandom_range(0, 2) == 0) ? (FLAG_ACK | FLAG_FIN) : FLAG_ACK;
      ST_ESTABLISHED: fl = ($urandom_range(0, 3) == 0) ? (FLAG_ACK | FLAG_FIN)
                                                       : (FLAG_ACK | FLAG_PSH);
      ST_FIN_WAIT_1: begin
        roll = $urandom_range(0, 2);
        if (roll == 0) fl = FLAG_ACK;
        else if (roll == 1) fl = FLAG_ACK | FLAG_FIN;
        else fl = FLAG_FIN;
      end
      ST_FIN_WAIT_2, ST_TIME_WAIT: fl = FLAG_ACK | FLAG_FIN;
      default: fl = FLAG_ACK;
    endcase
    if ($urandom_range(0, 9) == 0) begin
      fl = 8'($urandom());
      if ($urandom_range(0, 3) != 0) fl = fl & ~FLAG_RST;
    end
    it.seg_flags = fl;
    return it;
  endfunction

  task automatic push_event(input item_t it, input bit typed, input result_t typed_hdr);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    mode <= it.mode;
    seq_num <= it.seq_num;
    ack_num <= it.ack_num;
    seg_flags <= it.seg_flags;
    data_bytes <= it.data_bytes;
    peer_addr <= it.peer_addr;
    peer_port_in <= it.peer_port;
    initial_seq <= it.initial_seq;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    model_event(it);
    if (typed) expected_hdrs.push_back(typed_hdr);
    else for (int k = 0; k < hdr_n; k++) expected_hdrs.push_back(hdr_out[k]);
  endtask

  // requests without results may still be in flight when the queue empties
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_hdrs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_window(input logic [15:0] w);
    cfg_wr_data <= w;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    adv_win = w;
  endtask

  initial begin : result_sink
    int      hold;
    result_t got;
    result_t want;
    string   bad;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got = {is_segment, out_seq, out_ack, out_flags, out_window, payload_len,
               dest_addr, dest_port, conn_state, notify_app, last};
        if (expected_hdrs.size() == 0) begin
          if (fail_count < 10)
            $display("%0t unexpected result: seg=%0b seq=%h ack=%h flags=%h state=%0d",
                     $realtime, got.is_segment, got.out_seq, got.out_ack, got.out_flags,
                     got.conn_state);
          fail_count++;
        end else begin
          want = expected_hdrs.pop_front();
          bad = "";
          if (got.is_segment !== want.is_segment) bad = {bad, " is_segment"};
          if (got.out_seq !== want.out_seq) bad = {bad, " out_seq"};
          if (got.out_ack !== want.out_ack) bad = {bad, " out_ack"};
          if (got.out_flags !== want.out_flags) bad = {bad, " out_flags"};
          if (got.out_window !== want.out_window) bad = {bad, " out_window"};
          if (got.payload_len !== want.payload_len) bad = {bad, " payload_len"};
          if (got.dest_addr !== want.dest_addr) bad = {bad, " dest_addr"};
          if (got.dest_port !== want.dest_port) bad = {bad, " dest_port"};
          if (got.conn_state !== want.conn_state) bad = {bad, " conn_state"};
          if (got.notify_app !== want.notify_app) bad = {bad, " notify_app"};
          if (got.last !== want.last) bad = {bad, " last"};
          if (bad != "") begin
            if (fail_count < 10) begin
              $display("%0t mismatch in%s", $realtime, bad);
              $display("  exp: seg=%0b seq=%h ack=%h fl=%h win=%h len=%h",
                       want.is_segment, want.out_seq, want.out_ack, want.out_flags,
                       want.out_window, want.payload_len);
              $display("       addr=%h port=%h st=%0d n=%0b l=%0b",
                       want.dest_addr, want.dest_port, want.conn_state,
                       want.notify_app, want.last);
              $display("  act: seg=%0b seq=%h ack=%h fl=%h win=%h len=%h",
                       got.is_segment, got.out_seq, got.out_ack, got.out_flags,
                       got.out_window, got.payload_len);
              $display("       addr=%h port=%h st=%0d n=%0b l=%0b",
                       got.dest_addr, got.dest_port, got.conn_state,
                       got.notify_app, got.last);
            end
            fail_count++;
          end
        end
        hold = rx_steady ? 0 : $urandom_range(0, 6);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin : stimulus
    script_row_t script [$];
    item_t       it;
    int          done;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_window(RX_WINDOW_RESET);

    // closed: rst replies, reset wake-up, send with full length, ignored codes
    script.push_back('{mk_event(MODE_SEGMENT, '0, '0, '0, '0, '0, '0, '0), 1'b1,
                       mk_hdr(1'b1, '0, '0, FLAG_RST | FLAG_ACK, '0, '0, ST_CLOSED, 1'b0)});
    script.push_back('{mk_event(MODE_SEGMENT, 32'h1234_5678, '1, FLAG_ACK, '0, '0, '0, '0),
                       1'b1, mk_hdr(1'b1, '1, '0, FLAG_RST, '0, '0, ST_CLOSED, 1'b0)});
    script.push_back('{mk_event(MODE_SEGMENT, '1, '0, FLAG_SYN, '1, '0, '0, '0), 1'b1,
                       mk_hdr(1'b1, '0, 32'h0000_FFFF, FLAG_RST | FLAG_ACK, '0, '0,
                              ST_CLOSED, 1'b0)});
    script.push_back('{mk_event(MODE_SEGMENT, '1, '1, '1, '1, '1, '1, '1), 1'b1,
                       mk_hdr(1'b0, '0, '0, '0, '0, '0, ST_CLOSED, 1'b1)});
    script.push_back('{mk_event(MODE_SEND, '0, '0, '0, '1, '0, '0, '0), 1'b1,
                       mk_hdr(1'b1, '0, '0, FLAG_PSH | FLAG_ACK, '1, '1, ST_CLOSED, 1'b0)});
    script.push_back('{mk_event(MODE_UNUSED_LO, '0, '0, '0, '0, '0, '0, '0), 1'b0, '0});
    script.push_back('{mk_event(MODE_UNUSED_HI, '1, '1, '1, '1, '1, '1, '1), 1'b0, '0});
    script.push_back('{mk_event(MODE_CLOSE, '0, '0, '0, '0, '0, '0, '0), 1'b0, '0});
    // passive open with wrapping sequence numbers, then peer close
    script.push_back('{mk_event(MODE_LISTEN, '0, '0, '0, '0, '0, '0, '0), 1'b0, '0});
    script.push_back('{mk_event(MODE_SEGMENT, '0, '0, FLAG_ACK, '0, '0, '0, '0), 1'b0, '0});
    script.push_back('{mk_event(MODE_SEGMENT, '1, '0, FLAG_SYN, '0, '1, '1, '1), 1'b0, '0});
    // ack with fin and no payload: fin is left alone
    script.push_back('{mk_event(MODE_SEGMENT, '0, '0, FLAG_ACK | FLAG_FIN, '0, '0, '0, '0),
                       1'b0, '0});
    script.push_back('{mk_event(MODE_SEGMENT, '0, '0, FLAG_ACK | FLAG_FIN, 16'd16, '0, '0, '0),
                       1'b0, '0});
    script.push_back('{mk_event(MODE_CLOSE, '0, '0, '0, '0, '0, '0, '0), 1'b0, '0});
    script.push_back('{mk_event(MODE_SEGMENT, '0, 32'd1, FLAG_ACK, '0, '0, '0, '0), 1'b0, '0});
    // simultaneous open, then active close through closing
    script.push_back('{mk_event(MODE_CONNECT, '0, '0, '0, '0, 32'h0A00_0001, 16'd80, '0),
                       1'b0, '0});
    script.push_back('{mk_event(MODE_SEGMENT, 32'd100, '0, FLAG_SYN, '0, '0, '0, '0), 1'b0, '0});
    script.push_back('{mk_event(MODE_SEGMENT, 32'd101, 32'd1, FLAG_ACK, '0, '0, '0, '0),
                       1'b0, '0});
    script.push_back('{mk_event(MODE_SEND, '0, '0, '0, '0, '0, '0, '0), 1'b0, '0});
    script.push_back('{mk_event(MODE_SEGMENT, 32'd50, 32'd1, FLAG_ACK, 16'd5, '0, '0, '0),
                       1'b0, '0});
    script.push_back('{mk_event(MODE_CLOSE, '0, '0, '0, '0, '0, '0, '0), 1'b0, '0});
    // stale ack carrying fin in fin-wait-1
    script.push_back('{mk_event(MODE_SEGMENT, 32'd200, 32'd7, FLAG_ACK | FLAG_FIN, 16'd3,
                                '0, '0, '0), 1'b0, '0});
    script.push_back('{mk_event(MODE_SEGMENT, 32'd300, '0, FLAG_FIN, 16'd2, '0, '0, '0),
                       1'b0, '0});
    script.push_back('{mk_event(MODE_SEGMENT, '0, 32'd2, FLAG_ACK, '0, '0, '0, '0), 1'b0, '0});
    script.push_back('{mk_event(MODE_SEGMENT, '0, '0, FLAG_ACK | FLAG_FIN, '0, '0, '0, '0),
                       1'b0, '0});
    foreach (script[i]) push_event(script[i].ev, script[i].typed, script[i].hdr);
    drain_results();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) set_window(16'h0000);
      else if (p == 1) set_window(16'hFFFF);
      else set_window(16'($urandom()));
      tx_steady = (p == 2 || p == 5);
      rx_steady = (p == 3 || p == 5);
      done = 0;
      while (done < ITEMS_PER_PHASE) begin
        it = draw_event();
        push_event(it, 1'b0, '0);
        if (it.mode <= MODE_LISTEN) done++;
      end
      drain_results();
    end

    if (fail_count == 0 && expected_hdrs.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
